// File: rtl/core/sei_pkg.sv
// ----------------------------------------------------------------------------
// sei_pkg: shared types and constants
// Field widths, request kinds, register indexes, sequencer states and the
// sigmoid lookup table of the int8 squeeze-and-excitation block.
// ----------------------------------------------------------------------------
package sei_pkg;

   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_SQUEEZE  = 64;
   localparam int MAX_SPATIAL  = 16;

   localparam int FEAT_DEPTH = MAX_CHANNELS * MAX_SPATIAL;
   localparam int WGT_DEPTH  = MAX_SQUEEZE * MAX_CHANNELS;

   localparam int FEAT_AW = $clog2(FEAT_DEPTH);
   localparam int WGT_AW  = $clog2(WGT_DEPTH);
   localparam int CH_AW   = $clog2(MAX_CHANNELS);
   localparam int SQ_AW   = $clog2(MAX_SQUEEZE);
   localparam int PIX_AW  = $clog2(MAX_SPATIAL);
   localparam int DIV_W   = FEAT_AW;
   localparam int DIV_CW  = $clog2(DIV_W);

   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_FEATURE  = 3'd0,
      KIND_SQ_WGT   = 3'd1,
      KIND_SQ_BIAS  = 3'd2,
      KIND_EX_WGT   = 3'd3,
      KIND_EX_BIAS  = 3'd4,
      KIND_START    = 3'd5,
      KIND_DRAIN    = 3'd6,
      KIND_UNUSED   = 3'd7
   } kind_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_CHANNEL_COUNT  = 3'd0,
      REG_SPATIAL_SIZE   = 3'd1,
      REG_SQUEEZE_COUNT  = 3'd2,
      REG_SQUEEZE_SHIFT  = 3'd3,
      REG_EXCITE_SHIFT   = 3'd4,
      REG_OFFSET_MODE    = 3'd5,
      REG_SQ_BIAS_EN     = 3'd6,
      REG_EX_BIAS_EN     = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POOL_RD,
      ST_POOL_WT,
      ST_POOL_DIV,
      ST_POOL_WR,
      ST_SQ_RD,
      ST_SQ_WT,
      ST_SQ_WR,
      ST_EX_RD,
      ST_EX_WT,
      ST_EX_WR,
      ST_DONE,
      ST_DRAIN_CHK,
      ST_DRAIN_DIV,
      ST_DRAIN_RD,
      ST_DRAIN_OUT
   } state_type;

   typedef logic [6:0] steps_type [48];
   typedef logic [7:0] rom_type [256];

   // Smallest k at which the rounded curve reaches each level above 64
   localparam steps_type STEP_POINTS = '{
      7'd3,  7'd5,  7'd7,  7'd9,  7'd11, 7'd13, 7'd15, 7'd17,
      7'd19, 7'd21, 7'd23, 7'd25, 7'd27, 7'd29, 7'd31, 7'd33,
      7'd36, 7'd38, 7'd40, 7'd42, 7'd44, 7'd47, 7'd49, 7'd51,
      7'd54, 7'd56, 7'd59, 7'd61, 7'd64, 7'd66, 7'd69, 7'd71,
      7'd74, 7'd77, 7'd80, 7'd83, 7'd86, 7'd89, 7'd92, 7'd95,
      7'd99, 7'd102, 7'd106, 7'd110, 7'd114, 7'd118, 7'd122, 7'd127
   };

   function automatic rom_type sigmoid_table();
      rom_type t;
      int      v;
      for (int k = 0; k < 128; k++) begin
         v = 64;
         for (int m = 0; m < 48; m++) begin
            if (int'(STEP_POINTS[m]) <= k) begin
               v = v + 1;
            end
         end
         t[128 + k] = 8'(v);
         if (k > 0) begin
            t[128 - k] = 8'(127 - v);
         end
      end
      t[0] = 8'd15;
      return t;
   endfunction

   localparam rom_type SIGMOID_ROM = sigmoid_table();

endpackage

// File: rtl/core/sei_ram.sv
// ----------------------------------------------------------------------------
// sei_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sei_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/squeeze_excite_int8_top.sv
// ----------------------------------------------------------------------------
// squeeze_excite_int8_top: int8 squeeze-and-excitation block
//
// Requests on req_* carry a kind in req_tuser and a datum in req_tdata. Load
// kinds (features, squeeze/excite weights and biases) write the next entry of
// their store; a full store drops further loads.
// A start request runs pooling, the squeeze layer and the excite layer on one
// shared multiply-accumulate unit and a serial divider, then answers one
// response with compute_done set, using one MAC step per product and 14
// divider steps per pooled channel.
// A drain request answers one scaled feature, channel-major; the first drain
// after a register write first runs the divider to find the channel of the
// drain position. tlast marks the final element.
// csr_* writes registers by index and is always ready; the user must write only while idle (not enforced).
// Reset (synchronous) restores the registers and clears all load and drain
// counters; stores are undefined until written. A stalled response holds in
// the output register; loads are still taken meanwhile, and a start or drain
// waits for the register to free.
// ----------------------------------------------------------------------------
module squeeze_excite_int8_top
   import sei_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic [KIND_W-1:0]  req_tuser,   // [2:0] kind
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [7:0] scaled_feature
   output logic               rsp_tlast,   // last_element
   output logic               rsp_tuser,   // [0] compute_done
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_AW-1:0]  csr_index,
   input  logic [CSR_DW-1:0]  csr_data
);

   // registers
   logic [10:0] cfg_ch_ff;
   logic [4:0]  cfg_sp_ff;
   logic [6:0]  cfg_sq_ff;
   logic [4:0]  cfg_sq_shift_ff;
   logic [4:0]  cfg_ex_shift_ff;
   logic        cfg_offset_ff;
   logic        cfg_sq_bias_en_ff;
   logic        cfg_ex_bias_en_ff;

   state_type state_ff, state_in;

   logic [FEAT_AW:0]  cnt_feat_ff, cnt_feat_in;
   logic [WGT_AW:0]   cnt_sqw_ff, cnt_sqw_in;
   logic [SQ_AW:0]    cnt_sqb_ff, cnt_sqb_in;
   logic [WGT_AW:0]   cnt_exw_ff, cnt_exw_in;
   logic [CH_AW:0]    cnt_exb_ff, cnt_exb_in;

   logic [FEAT_AW-1:0] drn_n_ff, drn_n_in;
   logic [CH_AW-1:0]   drn_ch_ff, drn_ch_in;
   logic [PIX_AW-1:0]  drn_pix_ff, drn_pix_in;
   logic               drn_ok_ff, drn_ok_in;

   logic [CH_AW-1:0]  cnt_o_ff, cnt_o_in;
   logic [CH_AW-1:0]  cnt_i_ff, cnt_i_in;
   logic [WGT_AW-1:0] addr_ff, addr_in;
   logic              mac_vld_ff, mac_vld_in;
   logic              mac_first_ff, mac_first_in;
   logic [31:0]       acc_ff, acc_in;

   logic [DIV_W-1:0]  div_quo_ff, div_quo_in;
   logic [4:0]        div_rem_ff, div_rem_in;
   logic [DIV_CW-1:0] div_cnt_ff, div_cnt_in;

   logic [FEAT_AW:0]  total_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;

   // effective sizes
   logic [10:0] c_eff;
   logic [4:0]  sp_eff;
   logic [6:0]  q_eff;
   logic [15:0] total_full;

   always_comb begin
      if (cfg_ch_ff == 11'd0) c_eff = 11'd1;
      else if (cfg_ch_ff > 11'(MAX_CHANNELS)) c_eff = 11'(MAX_CHANNELS);
      else c_eff = cfg_ch_ff;
      if (cfg_sp_ff == 5'd0) sp_eff = 5'd1;
      else if (cfg_sp_ff > 5'(MAX_SPATIAL)) sp_eff = 5'(MAX_SPATIAL);
      else sp_eff = cfg_sp_ff;
      if (cfg_sq_ff == 7'd0) q_eff = 7'd1;
      else if (cfg_sq_ff > 7'(MAX_SQUEEZE)) q_eff = 7'(MAX_SQUEEZE);
      else q_eff = cfg_sq_ff;
   end

   assign total_full = 16'(c_eff) * 16'(sp_eff);

   logic [CH_AW-1:0]  c_last;
   logic [CH_AW-1:0]  q_last;
   logic [CH_AW-1:0]  sp_last;
   assign c_last  = CH_AW'(c_eff - 11'd1);
   assign q_last  = CH_AW'(q_eff - 7'd1);
   assign sp_last = CH_AW'(sp_eff - 5'd1);

   // RAM ports
   logic [7:0]  feat_rd, sqw_rd, exw_rd, pool_rd, sqz_rd, scale_rd;
   logic [31:0] sqb_rd, exb_rd;
   logic [FEAT_AW-1:0] feat_raddr;
   logic        feat_we, sqw_we, sqb_we, exw_we, exb_we;
   logic        pool_we, sqz_we, scale_we;
   logic [7:0]  pool_wd, sqz_wd, scale_wd;
   logic        req_acc;

   assign req_acc = req_tvalid && req_tready;
   assign feat_we = req_acc && (req_tuser == KIND_FEATURE) && !cnt_feat_ff[FEAT_AW];
   assign sqw_we  = req_acc && (req_tuser == KIND_SQ_WGT) && !cnt_sqw_ff[WGT_AW];
   assign sqb_we  = req_acc && (req_tuser == KIND_SQ_BIAS) && !cnt_sqb_ff[SQ_AW];
   assign exw_we  = req_acc && (req_tuser == KIND_EX_WGT) && !cnt_exw_ff[WGT_AW];
   assign exb_we  = req_acc && (req_tuser == KIND_EX_BIAS) && !cnt_exb_ff[CH_AW];

   assign feat_raddr = (state_ff == ST_DRAIN_RD || state_ff == ST_DRAIN_OUT) ? drn_n_ff
                                                                             : addr_ff[FEAT_AW-1:0];

   sei_ram #(.WIDTH(8), .DEPTH(FEAT_DEPTH)) u_feat (
      .clock(clock), .wr_en(feat_we), .wr_addr(cnt_feat_ff[FEAT_AW-1:0]),
      .wr_data(req_tdata[7:0]), .rd_addr(feat_raddr), .rd_data(feat_rd));
   sei_ram #(.WIDTH(8), .DEPTH(WGT_DEPTH)) u_sqw (
      .clock(clock), .wr_en(sqw_we), .wr_addr(cnt_sqw_ff[WGT_AW-1:0]),
      .wr_data(req_tdata[7:0]), .rd_addr(addr_ff), .rd_data(sqw_rd));
   sei_ram #(.WIDTH(32), .DEPTH(MAX_SQUEEZE)) u_sqb (
      .clock(clock), .wr_en(sqb_we), .wr_addr(cnt_sqb_ff[SQ_AW-1:0]),
      .wr_data(req_tdata), .rd_addr(cnt_o_ff[SQ_AW-1:0]), .rd_data(sqb_rd));
   sei_ram #(.WIDTH(8), .DEPTH(WGT_DEPTH)) u_exw (
      .clock(clock), .wr_en(exw_we), .wr_addr(cnt_exw_ff[WGT_AW-1:0]),
      .wr_data(req_tdata[7:0]), .rd_addr(addr_ff), .rd_data(exw_rd));
   sei_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_exb (
      .clock(clock), .wr_en(exb_we), .wr_addr(cnt_exb_ff[CH_AW-1:0]),
      .wr_data(req_tdata), .rd_addr(cnt_o_ff), .rd_data(exb_rd));
   sei_ram #(.WIDTH(8), .DEPTH(MAX_CHANNELS)) u_pool (
      .clock(clock), .wr_en(pool_we), .wr_addr(cnt_o_ff),
      .wr_data(pool_wd), .rd_addr(cnt_i_ff), .rd_data(pool_rd));
   sei_ram #(.WIDTH(8), .DEPTH(MAX_SQUEEZE)) u_sqz (
      .clock(clock), .wr_en(sqz_we), .wr_addr(cnt_o_ff[SQ_AW-1:0]),
      .wr_data(sqz_wd), .rd_addr(cnt_i_ff[SQ_AW-1:0]), .rd_data(sqz_rd));
   sei_ram #(.WIDTH(8), .DEPTH(MAX_CHANNELS)) u_scale (
      .clock(clock), .wr_en(scale_we), .wr_addr(cnt_o_ff),
      .wr_data(scale_wd), .rd_addr(drn_ch_ff), .rd_data(scale_rd));

   // shared multiply-accumulate unit
   logic signed [7:0]  mul_a, mul_b;
   logic signed [15:0] prod;
   logic [31:0]        acc_base;

   always_comb begin
      mul_a    = $signed(feat_rd);
      mul_b    = 8'sd1;
      acc_base = 32'd0;
      case (state_ff)
         ST_SQ_RD, ST_SQ_WT: begin
            mul_a    = $signed(pool_rd);
            mul_b    = $signed(sqw_rd);
            acc_base = cfg_sq_bias_en_ff ? sqb_rd : 32'd0;
         end
         ST_EX_RD, ST_EX_WT: begin
            mul_a    = $signed(sqz_rd);
            mul_b    = $signed(exw_rd);
            acc_base = cfg_ex_bias_en_ff ? exb_rd : 32'd0;
         end
         ST_DRAIN_OUT: begin
            mul_b = $signed(scale_rd);
         end
         default: begin
            mul_b = 8'sd1;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // serial restoring divider by the pixel count
   logic [DIV_W-1:0] div_src;
   logic [DIV_W-1:0] div_q;
   logic [4:0]       div_r;
   logic [5:0]       div_sh;
   logic             div_ge;
   logic [31:0]      acc_mag;

   assign acc_mag = acc_ff[31] ? (32'd0 - acc_ff) : acc_ff;
   assign div_src = (state_ff == ST_DRAIN_DIV) ? drn_n_ff : acc_mag[DIV_W-1:0];
   assign div_q   = (div_cnt_ff == '0) ? div_src : div_quo_ff;
   assign div_r   = (div_cnt_ff == '0) ? 5'd0 : div_rem_ff;
   assign div_sh  = {div_r, div_q[DIV_W-1]};
   assign div_ge  = div_sh >= {1'b0, sp_eff};
   assign div_rem_in = div_ge ? 5'(div_sh - {1'b0, sp_eff}) : div_sh[4:0];
   assign div_quo_in = {div_q[DIV_W-2:0], div_ge};

   logic div_last;
   assign div_last = div_cnt_ff == DIV_CW'(DIV_W - 1);

   // result formatting
   logic signed [DIV_W:0]  pool_q;
   logic signed [31:0]     sq_sh, ex_sh;
   logic signed [7:0]      ex_val;
   logic [7:0]             rom_idx;
   logic signed [15:0]     drn_sh;
   logic [7:0]             drn_val;

   always_comb begin
      pool_q = acc_ff[31] ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
      if (pool_q < -128) pool_wd = 8'h80;
      else if (pool_q > 127) pool_wd = 8'h7F;
      else pool_wd = pool_q[7:0];

      sq_sh = $signed(acc_ff) >>> cfg_sq_shift_ff;
      if (sq_sh < 0) sqz_wd = 8'd0;
      else if (sq_sh > 127) sqz_wd = 8'd127;
      else sqz_wd = sq_sh[7:0];

      ex_sh = $signed(acc_ff) >>> cfg_ex_shift_ff;
      if (ex_sh < -128) ex_val = -8'sd128;
      else if (ex_sh > 127) ex_val = 8'sd127;
      else ex_val = ex_sh[7:0];
      rom_idx  = cfg_offset_ff ? {~ex_val[7], ex_val[6:0]} : ex_val;
      scale_wd = SIGMOID_ROM[rom_idx];

      drn_sh = prod >>> 7;
      if (drn_sh < -128) drn_val = 8'h80;
      else if (drn_sh > 127) drn_val = 8'h7F;
      else drn_val = drn_sh[7:0];
   end

   // sequencer
   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_feat_in  = cnt_feat_ff + (FEAT_AW+1)'(feat_we);
      cnt_sqw_in   = cnt_sqw_ff + (WGT_AW+1)'(sqw_we);
      cnt_sqb_in   = cnt_sqb_ff + (SQ_AW+1)'(sqb_we);
      cnt_exw_in   = cnt_exw_ff + (WGT_AW+1)'(exw_we);
      cnt_exb_in   = cnt_exb_ff + (CH_AW+1)'(exb_we);
      drn_n_in     = drn_n_ff;
      drn_ch_in    = drn_ch_ff;
      drn_pix_in   = drn_pix_ff;
      drn_ok_in    = drn_ok_ff && !(csr_valid && csr_ready);
      cnt_o_in     = cnt_o_ff;
      cnt_i_in     = cnt_i_ff;
      addr_in      = addr_ff;
      mac_vld_in   = 1'b0;
      mac_first_in = 1'b0;
      acc_in       = acc_ff;
      div_cnt_in   = div_cnt_ff + DIV_CW'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      pool_we      = 1'b0;
      sqz_we       = 1'b0;
      scale_we     = 1'b0;

      if (mac_vld_ff) begin
         acc_in = (mac_first_ff ? acc_base : acc_ff) + 32'(prod);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser == KIND_START) begin
               cnt_o_in = '0;
               cnt_i_in = '0;
               addr_in  = '0;
               state_in = ST_POOL_RD;
            end else if (req_acc && req_tuser == KIND_DRAIN) begin
               state_in = ST_DRAIN_CHK;
            end
         end
         ST_POOL_RD, ST_SQ_RD, ST_EX_RD: begin
            mac_vld_in   = 1'b1;
            mac_first_in = cnt_i_ff == '0;
            addr_in      = addr_ff + WGT_AW'(1);
            cnt_i_in     = cnt_i_ff + CH_AW'(1);
            if ((state_ff == ST_POOL_RD && cnt_i_ff == sp_last) ||
                (state_ff == ST_SQ_RD && cnt_i_ff == c_last) ||
                (state_ff == ST_EX_RD && cnt_i_ff == q_last)) begin
               cnt_i_in = '0;
               case (state_ff)
                  ST_POOL_RD: state_in = ST_POOL_WT;
                  ST_SQ_RD:   state_in = ST_SQ_WT;
                  default:    state_in = ST_EX_WT;
               endcase
            end
         end
         ST_POOL_WT: begin
            div_cnt_in = '0;
            state_in   = ST_POOL_DIV;
         end
         ST_POOL_DIV: begin
            if (div_last) state_in = ST_POOL_WR;
         end
         ST_POOL_WR: begin
            pool_we = 1'b1;
            if (cnt_o_ff == c_last) begin
               cnt_o_in = '0;
               addr_in  = '0;
               state_in = ST_SQ_RD;
            end else begin
               cnt_o_in = cnt_o_ff + CH_AW'(1);
               state_in = ST_POOL_RD;
            end
         end
         ST_SQ_WT: state_in = ST_SQ_WR;
         ST_SQ_WR: begin
            sqz_we = 1'b1;
            if (cnt_o_ff == q_last) begin
               cnt_o_in = '0;
               addr_in  = '0;
               state_in = ST_EX_RD;
            end else begin
               cnt_o_in = cnt_o_ff + CH_AW'(1);
               state_in = ST_SQ_RD;
            end
         end
         ST_EX_WT: state_in = ST_EX_WR;
         ST_EX_WR: begin
            scale_we = 1'b1;
            if (cnt_o_ff == c_last) begin
               state_in = ST_DONE;
            end else begin
               cnt_o_in = cnt_o_ff + CH_AW'(1);
               state_in = ST_EX_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'd0;
               rsp_last_in  = 1'b0;
               rsp_done_in  = 1'b1;
               cnt_feat_in  = '0;
               cnt_sqw_in   = '0;
               cnt_sqb_in   = '0;
               cnt_exw_in   = '0;
               cnt_exb_in   = '0;
               drn_n_in     = '0;
               drn_ch_in    = '0;
               drn_pix_in   = '0;
               drn_ok_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DRAIN_CHK: begin
            if ({1'b0, drn_n_ff} >= total_ff) begin
               drn_n_in   = '0;
               drn_ch_in  = '0;
               drn_pix_in = '0;
               drn_ok_in  = 1'b1;
               state_in   = ST_DRAIN_RD;
            end else if (drn_ok_ff) begin
               state_in = ST_DRAIN_RD;
            end else begin
               div_cnt_in = '0;
               state_in   = ST_DRAIN_DIV;
            end
         end
         ST_DRAIN_DIV: begin
            if (div_last) begin
               drn_ch_in  = div_quo_in[CH_AW-1:0];
               drn_pix_in = div_rem_in[PIX_AW-1:0];
               drn_ok_in  = 1'b1;
               state_in   = ST_DRAIN_RD;
            end
         end
         ST_DRAIN_RD: state_in = ST_DRAIN_OUT;
         ST_DRAIN_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = drn_val;
               rsp_done_in  = 1'b0;
               rsp_last_in  = ({1'b0, drn_n_ff} + (FEAT_AW+1)'(1)) == total_ff;
               if (rsp_last_in) begin
                  drn_n_in   = '0;
                  drn_ch_in  = '0;
                  drn_pix_in = '0;
               end else begin
                  drn_n_in = drn_n_ff + FEAT_AW'(1);
                  if (CH_AW'(drn_pix_ff) == sp_last) begin
                     drn_pix_in = '0;
                     drn_ch_in  = drn_ch_ff + CH_AW'(1);
                  end else begin
                     drn_pix_in = drn_pix_ff + PIX_AW'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cfg_ch_ff         <= 11'd768;
         cfg_sp_ff         <= 5'd16;
         cfg_sq_ff         <= 7'd48;
         cfg_sq_shift_ff   <= 5'd0;
         cfg_ex_shift_ff   <= 5'd0;
         cfg_offset_ff     <= 1'b1;
         cfg_sq_bias_en_ff <= 1'b1;
         cfg_ex_bias_en_ff <= 1'b1;
         cnt_feat_ff       <= '0;
         cnt_sqw_ff        <= '0;
         cnt_sqb_ff        <= '0;
         cnt_exw_ff        <= '0;
         cnt_exb_ff        <= '0;
         drn_n_ff          <= '0;
         drn_ch_ff         <= '0;
         drn_pix_ff        <= '0;
         drn_ok_ff         <= 1'b1;
         mac_vld_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_feat_ff <= cnt_feat_in;
         cnt_sqw_ff <= cnt_sqw_in;
         cnt_sqb_ff <= cnt_sqb_in;
         cnt_exw_ff <= cnt_exw_in;
         cnt_exb_ff <= cnt_exb_in;
         drn_n_ff   <= drn_n_in;
         drn_ch_ff  <= drn_ch_in;
         drn_pix_ff <= drn_pix_in;
         drn_ok_ff  <= drn_ok_in;
         mac_vld_ff <= mac_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_CHANNEL_COUNT: cfg_ch_ff         <= csr_data;
               REG_SPATIAL_SIZE:  cfg_sp_ff         <= csr_data[4:0];
               REG_SQUEEZE_COUNT: cfg_sq_ff         <= csr_data[6:0];
               REG_SQUEEZE_SHIFT: cfg_sq_shift_ff   <= csr_data[4:0];
               REG_EXCITE_SHIFT:  cfg_ex_shift_ff   <= csr_data[4:0];
               REG_OFFSET_MODE:   cfg_offset_ff     <= csr_data[0];
               REG_SQ_BIAS_EN:    cfg_sq_bias_en_ff <= csr_data[0];
               REG_EX_BIAS_EN:    cfg_ex_bias_en_ff <= csr_data[0];
               default:           cfg_ch_ff         <= cfg_ch_ff;
            endcase
         end
      end
      // payload and datapath registers
      cnt_o_ff     <= cnt_o_in;
      cnt_i_ff     <= cnt_i_in;
      addr_ff      <= addr_in;
      mac_first_ff <= mac_first_in;
      acc_ff       <= acc_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_cnt_ff   <= div_cnt_in;
      total_ff     <= total_full[FEAT_AW:0];
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule
